@@ rtl/mdzr_pkg.sv @@
// package for the metric delta zero-run decoder
// record kinds, status codes and the result record type; no dependencies
package mdzr_pkg;

   localparam logic [1:0] KIND_SINGLE = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_SPAN   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_AFTER_END = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY  = 2'd2;

   localparam logic CSR_METRIC_COUNT = 1'b0;
   localparam logic CSR_SAMPLE_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  metric_index;
      logic [9:0]  end_metric_index;
      logic [15:0] sample_index;
      logic [15:0] run_length;
      logic [63:0] value;
      logic        last;
      logic [1:0]  status;
   } rec_type;

endpackage

@@ rtl/mdzr_divider.sv @@
// iterative unsigned divider, one quotient bit per cycle
// 64-bit dividend by 16-bit divisor; depends on nothing
module mdzr_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [63:0] quotient,
   output logic [15:0] remainder
);
   logic [63:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[15:0], quot_ff[63]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in  = shifted - {1'b0, divisor};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[15:0];
endmodule

@@ rtl/mdzr_ref_mem.sv @@
// reference value memory, one write and one registered read port
// depends on nothing
module mdzr_ref_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);
   logic [63:0] mem [DEPTH];
   logic [63:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

@@ rtl/metric_delta_zero_run_decoder_unit.sv @@
// top level of the metric delta zero-run decoder
// uses mdzr_pkg, mdzr_ref_mem and mdzr_divider
//
//  channel | ports                          | direction
//  req     | req_valid/ready, operation,word | in
//  rsp     | rsp_valid/ready, record fields  | out
//  csr     | csr_write, csr_index, csr_data  | in, write only
//
// a reference beat is taken in the accept step alone; a status-only beat is accepted, then emitted
// a delta goes through accept, memory read, add, emit
// a run count that spills past its metric goes through the bit-serial divider,
// then through the head-run memory read
// up to three records come out of one beat, one per cycle as rsp_ready allows
// reset is synchronous; the memory is not cleared
module metric_delta_zero_run_decoder_unit #(
   parameter int MAX_METRICS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [63:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_metric_index,
   output logic [9:0]  rsp_end_metric_index,
   output logic [15:0] rsp_sample_index,
   output logic [15:0] rsp_run_length,
   output logic [63:0] rsp_value,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import mdzr_pkg::*;

   localparam int AW = (MAX_METRICS > 1) ? $clog2(MAX_METRICS) : 1;
   // wide enough for the 11-bit register and for MAX_METRICS, plus one
   localparam int CW = (($clog2(MAX_METRICS + 1) > 11) ? $clog2(MAX_METRICS + 1) : 11) + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_ADD  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_HEAD = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [10:0]   mcount_ff;
   logic [15:0]   scount_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [63:0]   run_ff, run_in;
   logic [CW-1:0] cur_m_ff, cur_m_in;
   logic [15:0]   cur_s_ff, cur_s_in;
   logic          exp_ff, exp_in, done_ff, done_in;
   logic [63:0]   word_ff, word_in;

   // up to three queued records and their count
   rec_type       q_ff [3];
   rec_type       q_in [3];
   logic [1:0]    qn_ff, qn_in, qi_ff, qi_in;

   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [63:0]   mem_rd;
   logic          div_start, div_busy, div_done;
   logic [63:0]   div_q;
   logic [15:0]   div_r;
   logic [CW-1:0] head_m_ff, head_m_in;
   logic [15:0]   head_r_ff, head_r_in;

   logic [CW-1:0] eff_m;
   logic [CW-1:0] m1;
   logic [CW-1:0] avail;
   logic [63:0]   full;
   logic [63:0]   take;
   logic [16:0]   rem_s;
   logic [CW-1:0] next_m;
   rec_type       r;

   assign eff_m = ({{(CW-11){1'b0}}, mcount_ff} > CW'(MAX_METRICS)) ?
                  CW'(MAX_METRICS) : {{(CW-11){1'b0}}, mcount_ff};

   mdzr_ref_mem #(.DEPTH(MAX_METRICS), .AW(AW)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(req_word),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   mdzr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(word_ff),
      .divisor(scount_ff), .busy(div_busy), .done(div_done),
      .quotient(div_q), .remainder(div_r)
   );

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      run_in    = run_ff;
      cur_m_in  = cur_m_ff;
      cur_s_in  = cur_s_ff;
      exp_in    = exp_ff;
      done_in   = done_ff;
      word_in   = word_ff;
      qn_in     = qn_ff;
      qi_in     = qi_ff;
      head_m_in = head_m_ff;
      head_r_in = head_r_ff;
      for (int i = 0; i < 3; i++) q_in[i] = q_ff[i];
      mem_we    = 1'b0;
      mem_wa    = fill_ff[AW-1:0];
      mem_ra    = cur_m_ff[AW-1:0];
      div_start = 1'b0;
      req_ready = (state_ff == ST_IDLE);
      m1        = cur_m_ff + CW'(1);
      avail     = (m1 < eff_m) ? eff_m - m1 : '0;
      full      = '0;
      take      = '0;
      rem_s     = '0;
      next_m    = '0;
      r         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in = req_word;
               qn_in   = 2'd0;
               qi_in   = 2'd0;
               if (!req_operation) begin
                  if (fill_ff < eff_m) begin
                     mem_we  = 1'b1;
                     fill_in = fill_ff + CW'(1);
                  end else begin
                     r.kind    = KIND_STATUS;
                     r.status  = STATUS_TOO_MANY;
                     r.last    = 1'b1;
                     q_in[0]   = r;
                     qn_in     = 2'd1;
                     state_in  = ST_EMIT;
                  end
               end else if (!exp_ff) begin
                  // advance past a finished metric, then check for end
                  if (!done_ff && scount_ff != 16'd0 && cur_s_ff >= scount_ff) begin
                     cur_m_in = cur_m_ff + CW'(1);
                     cur_s_in = '0;
                  end
                  if (done_ff || cur_m_in >= eff_m || scount_ff == 16'd0) begin
                     done_in  = 1'b1;
                     r.kind   = KIND_STATUS;
                     r.status = STATUS_AFTER_END;
                     r.last   = 1'b1;
                     q_in[0]  = r;
                     qn_in    = 2'd1;
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  // run count beat
                  exp_in = 1'b0;
                  rem_s  = (cur_s_ff < scount_ff) ? {1'b0, scount_ff - cur_s_ff} : '0;
                  if (req_word != 64'd0 && rem_s != 17'd0) begin
                     take = (req_word < {47'd0, rem_s}) ? req_word : {47'd0, rem_s};
                     r.kind             = KIND_RUN;
                     r.metric_index     = 10'(cur_m_ff);
                     r.end_metric_index = 10'(cur_m_ff);
                     r.sample_index     = cur_s_ff + 16'd1;
                     r.run_length       = take[15:0];
                     r.value            = run_ff;
                     q_in[0]  = r;
                     qn_in    = 2'd1;
                     cur_s_in = cur_s_ff + take[15:0];
                     word_in  = req_word - take;
                  end
                  if (word_in != 64'd0 && scount_ff != 16'd0) begin
                     state_in = ST_DIV;
                  end else begin
                     if (cur_s_in >= scount_ff) begin
                        cur_m_in = cur_m_ff + CW'(1);
                        cur_s_in = '0;
                     end
                     if (cur_m_in >= eff_m) done_in = 1'b1;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            run_in   = ((cur_s_ff == 16'd0) ? mem_rd : run_ff) + word_ff;
            cur_s_in = cur_s_ff + 16'd1;
            r.kind             = KIND_SINGLE;
            r.metric_index     = 10'(cur_m_ff);
            r.end_metric_index = 10'(cur_m_ff);
            r.sample_index     = cur_s_in;
            r.run_length       = 16'd1;
            r.value            = run_in;
            r.last             = 1'b1;
            q_in[0] = r;
            qn_in   = 2'd1;
            if (word_ff == 64'd0) begin
               exp_in = 1'b1;
            end else begin
               if (cur_s_in >= scount_ff) begin
                  cur_m_in = cur_m_ff + CW'(1);
                  cur_s_in = '0;
               end
               if (cur_m_in >= eff_m) done_in = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_DIV: begin
            // cur_m_ff is the current metric; word_ff holds what spills
            if (!div_busy && !div_done) begin
               div_start = 1'b1;
            end else if (div_done) begin
               full = div_q;
               if (div_q >= {{(64-CW){1'b0}}, avail}) begin
                  full  = {{(64-CW){1'b0}}, avail};
                  rem_s = '0;
               end else begin
                  rem_s = {1'b0, div_r};
               end
               if (full != 64'd0) begin
                  r.kind             = KIND_SPAN;
                  r.metric_index     = 10'(m1);
                  r.end_metric_index = 10'(cur_m_ff + full[CW-1:0]);
                  r.sample_index     = 16'd1;
                  r.run_length       = scount_ff;
                  q_in[qn_ff] = r;
                  qn_in       = qn_ff + 2'd1;
               end
               next_m    = m1 + full[CW-1:0];
               cur_m_in  = next_m;
               head_m_in = next_m;
               head_r_in = rem_s[15:0];
               if (rem_s != 17'd0) begin
                  cur_s_in = rem_s[15:0];
                  state_in = ST_HEAD;
               end else begin
                  cur_s_in = '0;
                  if (next_m >= eff_m) done_in = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_HEAD: begin
            // wait on qi_ff while the memory reads at cur_m_ff, then take its registered data
            if (qi_ff == 2'd0) begin
               qi_in = 2'd1;
            end else begin
               qi_in  = 2'd0;
               run_in = mem_rd;
               r.kind             = KIND_RUN;
               r.metric_index     = 10'(head_m_ff);
               r.end_metric_index = 10'(head_m_ff);
               r.sample_index     = 16'd1;
               r.run_length       = head_r_ff;
               r.value            = mem_rd;
               q_in[qn_ff] = r;
               qn_in       = qn_ff + 2'd1;
               if (cur_s_ff >= scount_ff) begin
                  cur_m_in = cur_m_ff + CW'(1);
                  cur_s_in = '0;
               end
               if (cur_m_in >= eff_m) done_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (qn_ff == 2'd0) begin
               state_in = ST_IDLE;
            end else if (rsp_ready) begin
               if (qi_ff + 2'd1 == qn_ff) begin
                  qi_in    = 2'd0;
                  state_in = ST_IDLE;
               end else begin
                  qi_in = qi_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      head_m_ff <= head_m_in;
      head_r_ff <= head_r_in;
      for (int i = 0; i < 3; i++) q_ff[i] <= q_in[i];
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         run_ff    <= '0;
         cur_m_ff  <= '0;
         cur_s_ff  <= '0;
         exp_ff    <= 1'b0;
         done_ff   <= 1'b0;
         qn_ff     <= '0;
         qi_ff     <= '0;
         mcount_ff <= 11'd1;
         scount_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         run_ff   <= run_in;
         cur_m_ff <= cur_m_in;
         cur_s_ff <= cur_s_in;
         exp_ff   <= exp_in;
         done_ff  <= done_in;
         qn_ff    <= qn_in;
         qi_ff    <= qi_in;
         if (csr_write) begin
            case (csr_index)
               CSR_METRIC_COUNT: mcount_ff <= csr_data[10:0];
               CSR_SAMPLE_COUNT: scount_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // last flag set on the final queued record
   assign rsp_valid            = (state_ff == ST_EMIT) && (qn_ff != 2'd0);
   assign rsp_kind             = q_ff[qi_ff].kind;
   assign rsp_metric_index     = q_ff[qi_ff].metric_index;
   assign rsp_end_metric_index = q_ff[qi_ff].end_metric_index;
   assign rsp_sample_index     = q_ff[qi_ff].sample_index;
   assign rsp_run_length       = q_ff[qi_ff].run_length;
   assign rsp_value            = q_ff[qi_ff].value;
   assign rsp_last             = (qi_ff + 2'd1 == qn_ff);
   assign rsp_status           = q_ff[qi_ff].status;
endmodule

@@ rtl/mdzr_checker.sv @@
// port-level checks for the metric delta zero-run decoder
// bound to metric_delta_zero_run_decoder_unit; depends on mdzr_pkg
module mdzr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import mdzr_pkg::*;

   // no new request taken while a record waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");

   // status codes only on status records
   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_kind == KIND_STATUS)
      else $error("status on data record");

   // status records are always last
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_last)
      else $error("status record not last");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("response dropped");
endmodule

bind metric_delta_zero_run_decoder_unit mdzr_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
   .rsp_status(rsp_status), .rsp_last(rsp_last)
);

@@ sim/testbench.sv @@
// self-checking testbench for metric_delta_zero_run_decoder_unit
// holds its own predictor of the decoder and a directed table followed by random phases
// depends on mdzr_pkg and the rtl top level only
module testbench;
   import mdzr_pkg::*;

   localparam int IDLE_LIMIT  = 3000;   // cycles with no beat on either side
   localparam int SETTLE_WAIT = 150;    // covers the divider on a spilling run
   localparam int HOLD_CYCLES = 400;    // long receiver stall, fills the block

   typedef struct {
      bit          op;
      logic [63:0] word;
      bit          typed;      // expected record typed in below
      rec_type     rec;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [63:0] req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [9:0]  rsp_metric_index;
   logic [9:0]  rsp_end_metric_index;
   logic [15:0] rsp_sample_index;
   logic [15:0] rsp_run_length;
   logic [63:0] rsp_value;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   // predictor state, a shadow of the decoder
   logic [63:0] ref_values [0:1023];
   int unsigned ref_fill, cur_metric, cur_sample, metric_cfg, sample_cfg;
   logic [63:0] run_value;
   bit          want_run_count, stream_ended;

   rec_type      beat_records[$];    // records predicted for one beat
   rec_type      pending_records[$]; // records still to come out
   stim_row_type directed_rows[$];
   int           errors = 0;
   int           beats_sent = 0;
   int           records_seen = 0;
   int           idle_cycles = 0;

   metric_delta_zero_run_decoder_unit dut (.*);

   always #6 clock = ~clock;

   function automatic rec_type make_rec(logic [1:0] kind, int unsigned m, int unsigned em,
                                        int unsigned si, int unsigned rl, logic [63:0] val,
                                        logic [1:0] st);
      rec_type r;
      r.kind = kind;
      r.metric_index = m[9:0];
      r.end_metric_index = em[9:0];
      r.sample_index = si[15:0];
      r.run_length = rl[15:0];
      r.value = val;
      r.last = 1'b0;
      r.status = st;
      return r;
   endfunction

   // one row of the directed table
   function automatic void add_row(bit op, logic [63:0] w, bit typed, rec_type rec);
      stim_row_type row;
      row.op = op;
      row.word = w;
      row.typed = typed;
      row.rec = rec;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void settle_position(int unsigned m_eff);
      if (cur_sample >= sample_cfg) begin
         cur_metric++;
         cur_sample = 0;
      end
      if (cur_metric >= m_eff) stream_ended = 1;
   endfunction

   // decode one beat into beat_records, updating the shadow state
   function automatic void decode_beat(bit op, logic [63:0] w);
      int unsigned m_eff;
      longint unsigned z, left, take, avail, full, rem;
      int unsigned nxt;
      logic [63:0] base;
      m_eff = (metric_cfg > 1024) ? 1024 : metric_cfg;
      beat_records.delete();
      if (op == 1'b0) begin
         if (ref_fill < m_eff) begin
            ref_values[ref_fill] = w;
            ref_fill++;
         end else begin
            beat_records.insert(beat_records.size(),
                                make_rec(KIND_STATUS, 0, 0, 0, 0, 0, STATUS_TOO_MANY));
         end
      end else if (!want_run_count) begin
         if (!stream_ended && sample_cfg != 0 && cur_sample >= sample_cfg) begin
            cur_metric++;
            cur_sample = 0;
         end
         if (stream_ended || cur_metric >= m_eff || sample_cfg == 0) begin
            stream_ended = 1;
            beat_records.insert(beat_records.size(),
                                make_rec(KIND_STATUS, 0, 0, 0, 0, 0, STATUS_AFTER_END));
         end else begin
            base = (cur_sample == 0) ? ref_values[cur_metric] : run_value;
            run_value = base + w;
            cur_sample++;
            beat_records.insert(beat_records.size(),
                                make_rec(KIND_SINGLE, cur_metric, cur_metric, cur_sample,
                                         1, run_value, STATUS_OK));
            if (w == 0) want_run_count = 1;
            else settle_position(m_eff);
         end
      end else begin
         // zero-run count: rest of this metric, whole metrics, then a head run
         z = w;
         left = (cur_sample < sample_cfg) ? longint'(sample_cfg - cur_sample) : 0;
         want_run_count = 0;
         if (z > 0 && left > 0) begin
            take = (z < left) ? z : left;
            beat_records.insert(beat_records.size(),
                                make_rec(KIND_RUN, cur_metric, cur_metric, cur_sample + 1,
                                         int'(take), run_value, STATUS_OK));
            cur_sample += int'(take);
            z -= take;
         end
         if (z > 0 && sample_cfg != 0) begin
            avail = (cur_metric + 1 < m_eff) ? longint'(m_eff - cur_metric - 1) : 0;
            full = z / sample_cfg;
            rem = z % sample_cfg;
            if (full >= avail) begin
               full = avail;
               rem = 0;
            end
            if (full > 0)
               beat_records.insert(beat_records.size(),
                                   make_rec(KIND_SPAN, cur_metric + 1,
                                            cur_metric + int'(full), 1, sample_cfg, 0,
                                            STATUS_OK));
            nxt = cur_metric + 1 + int'(full);
            cur_metric = nxt;
            if (rem > 0) begin
               run_value = ref_values[nxt];
               beat_records.insert(beat_records.size(),
                                   make_rec(KIND_RUN, nxt, nxt, 1, int'(rem), run_value,
                                            STATUS_OK));
               cur_sample = int'(rem);
            end else begin
               cur_sample = 0;
            end
         end
         settle_position(m_eff);
      end
      if (beat_records.size() > 0) beat_records[beat_records.size() - 1].last = 1'b1;
   endfunction

   // one beat on the request side, with a random gap in front
   task automatic send_beat(bit op, logic [63:0] w);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation = op;
      req_word = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      beats_sent++;
      @(negedge clock);
   endtask

   // predicted beat: expected records queued before the beat goes out
   task automatic predicted_beat(bit op, logic [63:0] w);
      decode_beat(op, w);
      foreach (beat_records[i]) pending_records.insert(pending_records.size(), beat_records[i]);
      send_beat(op, w);
   endtask

   // register writes only with the block idle
   task automatic write_csr(logic idx, int unsigned data);
      req_valid = 1'b0;
      wait (pending_records.size() == 0);
      repeat (SETTLE_WAIT) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data[15:0];
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == CSR_METRIC_COUNT) metric_cfg = data & 32'h7FF;
      else sample_cfg = data & 32'hFFFF;
   endtask

   // next stream word drawn from the shadow state
   task automatic random_word(bit big_runs);
      logic [63:0] w;
      if ($urandom_range(0, 99) < 8) begin
         // noise: a surplus reference
         predicted_beat(1'b0, {$urandom, $urandom});
      end else if (want_run_count) begin
         if (big_runs && $urandom_range(0, 1)) w = {$urandom, $urandom};
         else w = $urandom_range(0, 3 * sample_cfg);
         predicted_beat(1'b1, w);
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: w = '0;
            3, 4, 5: w = $urandom_range(1, 9);
            default: w = {$urandom, $urandom};
         endcase
         predicted_beat(1'b1, w);
      end
   endtask

   // response side: random ready gaps, one long hold-off
   initial begin : receiver
      int wait_cycles;
      bit held;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (!held && records_seen >= 40) begin
            held = 1;
            wait_cycles = HOLD_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // result checking and watchdog
   always @(posedge clock) begin
      rec_type exp_rec;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            records_seen++;
            if (pending_records.size() == 0) begin
               $error("unexpected record, kind %0d status %0d", rsp_kind, rsp_status);
               errors++;
            end else begin
               exp_rec = pending_records.pop_front();
               if (rsp_kind !== exp_rec.kind) begin
                  $error("kind: expected %0d, got %0d", exp_rec.kind, rsp_kind);
                  errors++;
               end
               if (rsp_metric_index !== exp_rec.metric_index) begin
                  $error("metric_index: expected %0d, got %0d", exp_rec.metric_index,
                         rsp_metric_index);
                  errors++;
               end
               if (rsp_end_metric_index !== exp_rec.end_metric_index) begin
                  $error("end_metric_index: expected %0d, got %0d", exp_rec.end_metric_index,
                         rsp_end_metric_index);
                  errors++;
               end
               if (rsp_sample_index !== exp_rec.sample_index) begin
                  $error("sample_index: expected %0d, got %0d", exp_rec.sample_index,
                         rsp_sample_index);
                  errors++;
               end
               if (rsp_run_length !== exp_rec.run_length) begin
                  $error("run_length: expected %0d, got %0d", exp_rec.run_length,
                         rsp_run_length);
                  errors++;
               end
               if (rsp_value !== exp_rec.value) begin
                  $error("value: expected %h, got %h", exp_rec.value, rsp_value);
                  errors++;
               end
               if (rsp_last !== exp_rec.last) begin
                  $error("last: expected %0d, got %0d", exp_rec.last, rsp_last);
                  errors++;
               end
               if (rsp_status !== exp_rec.status) begin
                  $error("status: expected %0d, got %0d", exp_rec.status, rsp_status);
                  errors++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("** metric_delta_zero_run_decoder_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      rec_type first_rec, too_many_rec;
      int phase_words;
      int added;
      ref_fill = 0; cur_metric = 0; cur_sample = 0; run_value = '0;
      want_run_count = 0; stream_ended = 0; metric_cfg = 1; sample_cfg = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed table: 6 metrics of 4 samples
      write_csr(CSR_METRIC_COUNT, 6);
      write_csr(CSR_SAMPLE_COUNT, 4);
      first_rec = make_rec(KIND_SINGLE, 0, 0, 1, 1, '1, STATUS_OK);
      first_rec.last = 1'b1;
      too_many_rec = make_rec(KIND_STATUS, 0, 0, 0, 0, 0, STATUS_TOO_MANY);
      too_many_rec.last = 1'b1;
      add_row(1'b0, 64'h0, 1'b0, '0);
      add_row(1'b0, '1, 1'b0, '0);
      add_row(1'b0, 64'h5555_5555_5555_5555, 1'b0, '0);
      add_row(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
      add_row(1'b0, 64'h1, 1'b0, '0);
      add_row(1'b0, 64'h8000_0000_0000_0000, 1'b0, '0);
      add_row(1'b0, 64'h1234, 1'b1, too_many_rec);   // surplus reference
      add_row(1'b1, '1, 1'b1, first_rec);            // largest delta
      add_row(1'b1, 64'h1, 1'b0, '0);                // wraps to zero
      add_row(1'b1, 64'h0, 1'b0, '0);                // zero delta
      add_row(1'b1, 64'h0, 1'b0, '0);                // run count of zero
      add_row(1'b1, 64'h0, 1'b0, '0);
      add_row(1'b1, 64'd9, 1'b0, '0);                // spans then head run
      add_row(1'b1, 64'd5, 1'b0, '0);
      add_row(1'b1, 64'h0, 1'b0, '0);
      add_row(1'b1, 64'd2, 1'b0, '0);                // tail then head run
      add_row(1'b1, 64'h0, 1'b0, '0);
      add_row(1'b1, 64'd1, 1'b0, '0);                // run inside metric
      add_row(1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0);
      foreach (directed_rows[i]) begin
         decode_beat(directed_rows[i].op, directed_rows[i].word);
         if (directed_rows[i].typed)
            pending_records.insert(pending_records.size(), directed_rows[i].rec);
         else
            foreach (beat_records[j])
               pending_records.insert(pending_records.size(), beat_records[j]);
         send_beat(directed_rows[i].op, directed_rows[i].word);
      end

      // random phases: grow the metric count, load its references, stream words
      for (int phase = 0; beats_sent < 240; phase++) begin
         added = $urandom_range(6, 14);
         write_csr(CSR_METRIC_COUNT, metric_cfg + added);
         write_csr(CSR_SAMPLE_COUNT, (phase == 0) ? 1 : $urandom_range(1, 6));
         while (ref_fill < metric_cfg) predicted_beat(1'b0, {$urandom, $urandom});
         phase_words = 0;
         while (phase_words < 26 && (want_run_count || cur_metric + 4 < metric_cfg)) begin
            random_word(1'b0);
            phase_words++;
         end
      end

      // longest metrics, huge runs that run off the last metric
      write_csr(CSR_SAMPLE_COUNT, 65535);
      phase_words = 0;
      while (!stream_ended && phase_words < 40) begin
         random_word(1'b1);
         phase_words++;
      end
      repeat (3) random_word(1'b1);

      // register extremes after the end of the stream
      write_csr(CSR_METRIC_COUNT, 2047);
      write_csr(CSR_SAMPLE_COUNT, 0);
      repeat (3) predicted_beat(1'b0, {$urandom, $urandom});
      repeat (2) predicted_beat(1'b1, {$urandom, $urandom});
      write_csr(CSR_METRIC_COUNT, 0);
      predicted_beat(1'b0, '1);
      predicted_beat(1'b1, '0);

      req_valid = 1'b0;
      wait (pending_records.size() == 0);
      repeat (SETTLE_WAIT) @(negedge clock);
      $display("covered %0d request beats and %0d records over %0d loaded references",
               beats_sent, records_seen, ref_fill);
      if (errors == 0 && pending_records.size() == 0)
         $display("** metric_delta_zero_run_decoder_unit: PASSED **");
      else
         $display("** metric_delta_zero_run_decoder_unit: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mdzr_pkg.sv
rtl/mdzr_divider.sv
rtl/mdzr_ref_mem.sv
rtl/metric_delta_zero_run_decoder_unit.sv
rtl/mdzr_checker.sv
sim/testbench.sv
